FILE: hw/rtl/falc_pkg.sv
// ----------------------------------------------------------------------------
// falc_pkg
// Shared sizes and types for the fully associative lru cache lookup.
// ----------------------------------------------------------------------------
package falc_pkg;

	localparam int NUM_LINES      = 8;
	localparam int WORDS_PER_LINE = 4;
	localparam int ADDR_BITS      = 32;
	localparam int AGE_BITS       = 16;
	localparam int COUNT_W        = 32;
	localparam int USED_W         = 3;

	localparam int LINE_W   = $clog2(NUM_LINES);
	localparam int OFFSET_W = $clog2(WORDS_PER_LINE);
	localparam int TAG_W    = ADDR_BITS - OFFSET_W;

	typedef logic [LINE_W-1:0]   line_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [AGE_BITS-1:0] age_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef tag_t [NUM_LINES-1:0] tag_vec_t;
	typedef age_t [NUM_LINES-1:0] age_vec_t;
	typedef logic [NUM_LINES-1:0] line_mask_t;

	typedef struct packed {
		logic  hit;
		line_t idx;
	} match_t;

endpackage

FILE: hw/rtl/falc_match.sv
// ----------------------------------------------------------------------------
// falc_match
// Parallel tag compare over all lines; lowest matching valid line wins.
// ----------------------------------------------------------------------------
module falc_match (
	input  falc_pkg::tag_vec_t   tags,
	input  falc_pkg::line_mask_t valid,
	input  falc_pkg::tag_t       lookup,
	output falc_pkg::match_t     result
);
	import falc_pkg::*;

	always_comb begin
		result.hit = 1'b0;
		result.idx = '0;
		// scan downward so the lowest index is the one left standing
		for (int k = NUM_LINES - 1; k >= 0; k--) begin
			if (valid[k] && (tags[k] == lookup)) begin
				result.hit = 1'b1;
				result.idx = LINE_W'(k);
			end
		end
	end

endmodule

FILE: hw/rtl/falc_victim.sv
// ----------------------------------------------------------------------------
// falc_victim
// Picks the oldest line for refill; ties resolve to the lowest index.
// ----------------------------------------------------------------------------
module falc_victim (
	input  falc_pkg::age_vec_t ages,
	output falc_pkg::line_t    victim
);
	import falc_pkg::*;

	age_t best_age;

	always_comb begin
		best_age = ages[0];
		victim   = '0;
		// strict compare keeps the earlier line on equal ages
		for (int k = 1; k < NUM_LINES; k++) begin
			if (ages[k] > best_age) begin
				best_age = ages[k];
				victim   = LINE_W'(k);
			end
		end
	end

endmodule

FILE: hw/rtl/fully_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_lookup
// Hit/miss tracking for an 8-line fully associative cache with lru refill.
//
//   channel   direction   handshake              payload
//   in        request     in_valid / in_ready    word_address
//   out       result      out_valid / out_ready  was_hit, line_used,
//                                                hits_so_far, misses_so_far
//
// One request per cycle while the result is not stalled: a request sits in the
// input register, then tag compare, victim pick and state update happen at the
// edge that loads the result register.
// Reset clears valid bits, ages and counts at once; tags are not cleared.
// A stalled result holds the input register, which then holds in_ready low.
// ----------------------------------------------------------------------------
module fully_assoc_lru_cache_lookup (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [falc_pkg::ADDR_BITS-1:0]     word_address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               was_hit,
	output logic [falc_pkg::USED_W-1:0]        line_used,
	output logic [falc_pkg::COUNT_W-1:0]       hits_so_far,
	output logic [falc_pkg::COUNT_W-1:0]       misses_so_far
);
	import falc_pkg::*;

	logic       valid_s1;
	tag_t       tag_s1;
	logic       out_valid_q;
	logic       was_hit_s2;
	line_t      line_used_s2;

	tag_vec_t   line_tag_q;
	line_mask_t line_valid_q;
	age_vec_t   line_age_q;
	count_t     hit_total_q;
	count_t     miss_total_q;

	match_t     match;
	line_t      victim;
	line_t      used;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign used     = match.hit ? match.idx : victim;

	falc_match u_match (
		.tags   (line_tag_q),
		.valid  (line_valid_q),
		.lookup (tag_s1),
		.result (match)
	);

	falc_victim u_victim (
		.ages   (line_age_q),
		.victim (victim)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tag_s1 <= word_address[ADDR_BITS-1:OFFSET_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			was_hit_s2   <= match.hit;
			line_used_s2 <= used;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !match.hit) begin
			line_tag_q[victim] <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			line_age_q   <= '0;
			hit_total_q  <= '0;
			miss_total_q <= '0;
		end else if (advance) begin
			if (match.hit) begin
				if (hit_total_q != '1) begin
					hit_total_q <= hit_total_q + 1'b1;
				end
			end else begin
				line_valid_q[victim] <= 1'b1;
				if (miss_total_q != '1) begin
					miss_total_q <= miss_total_q + 1'b1;
				end
			end
			for (int k = 0; k < NUM_LINES; k++) begin
				if (LINE_W'(k) == used) begin
					line_age_q[k] <= '0;
				end else if (line_age_q[k] != '1) begin
					line_age_q[k] <= line_age_q[k] + 1'b1;
				end
			end
		end
	end

	// counts only move on advance, which waits for the pending result to go
	assign out_valid     = out_valid_q;
	assign was_hit       = was_hit_s2;
	assign line_used     = USED_W'(line_used_s2);
	assign hits_so_far   = hit_total_q;
	assign misses_so_far = miss_total_q;

`ifndef NO_ASSERTIONS
	a_valid_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((line_valid_q & $past(line_valid_q)) == $past(line_valid_q)))
		else $error("line valid bit dropped");

	a_used_age_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (line_age_q[$past(used)] == '0))
		else $error("used line age not cleared");

	a_refill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !match.hit) |=> line_valid_q[$past(victim)])
		else $error("refilled line not marked valid");

	a_one_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(hit_total_q) && $stable(miss_total_q)))
		else $error("count moved without a request");
`endif

endmodule
